// File: design/lltsi_pkg.sv
`timescale 1ns / 1ps

package lltsi_pkg;

	// Frame geometry
	localparam logic [8:0] DotsPerLine   = 9'd456;
	localparam logic [8:0] OamStartDot   = 9'd4;
	localparam logic [8:0] DrawStartDot  = 9'd84;
	localparam logic [8:0] CmpEndDot     = 9'd8;
	localparam logic [8:0] CmpLateDot    = 9'd12;
	localparam logic [7:0] VblankLine    = 8'd144;
	localparam logic [7:0] LinesPerFrame = 8'd154;
	localparam logic [7:0] LastLine      = 8'd153;

	// Reset values
	localparam logic [7:0] CtrlReset     = 8'h91;
	localparam logic [8:0] DotReset      = 9'd4;

	// Status read: fixed top bit, enables field mask
	localparam logic [7:0] StatTopBit    = 8'h80;
	localparam logic [7:0] StatEnMask    = 8'h78;

	// Operation codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Register selects
	localparam logic [1:0] REG_CTRL = 2'd0;
	localparam logic [1:0] REG_STAT = 2'd1;
	localparam logic [1:0] REG_LINE = 2'd2;
	localparam logic [1:0] REG_LYC  = 2'd3;

	// Display modes
	localparam logic [1:0] MODE_HBLANK = 2'd0;
	localparam logic [1:0] MODE_VBLANK = 2'd1;
	localparam logic [1:0] MODE_OAM    = 2'd2;
	localparam logic [1:0] MODE_DRAW   = 2'd3;

	typedef struct packed {
		logic [1:0] operation;
		logic [1:0] reg_select;
		logic [7:0] write_data;
		logic       draw_done;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [1:0] lcd_mode;
		logic [7:0] line_number;
		logic       vblank_irq;
		logic       stat_irq;
		logic       frame_done;
	} result_t;

endpackage

// File: design/lltsi_if.sv
`timescale 1ns / 1ps

// Input word channel
interface lltsi_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [1:0] reg_select;
	logic [7:0] write_data;
	logic       draw_done;

	modport source (output valid, operation, reg_select, write_data, draw_done,
		input ready);
	modport sink (input valid, operation, reg_select, write_data, draw_done,
		output ready);
endinterface

// Result word channel
interface lltsi_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [1:0] lcd_mode;
	logic [7:0] line_number;
	logic       vblank_irq;
	logic       stat_irq;
	logic       frame_done;

	modport source (output valid, read_data, lcd_mode, line_number, vblank_irq,
		stat_irq, frame_done, input ready);
	modport sink (input valid, read_data, lcd_mode, line_number, vblank_irq,
		stat_irq, frame_done, output ready);
endinterface

// File: design/lcd_line_timing_stat_irq.sv
`timescale 1ns / 1ps

// An input word passes through the input register and then the result register before its result word is valid.
// Throughput: one word per cycle while results are taken; the whole update is a single pass through the core logic.
// A waiting result holds the input register; one more word is taken only while it is empty.
// Reset (arst_n low, asynchronous): LCD on, dot 4 of line 0, hblank, compare flag set,
// status enables and line compare cleared, both pipeline stages empty.
module lcd_line_timing_stat_irq import lltsi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	lltsi_cmd_if.sink   cmd,
	lltsi_rsp_if.source rsp
);

	logic    vld_s1;
	item_t   item_s1;
	logic    vld_s2;
	result_t res_s2;
	result_t res_c;
	logic    adv;

	// Advance stage 1 into the result register when it is free
	assign adv       = !vld_s2 || rsp.ready;
	assign cmd.ready = !vld_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1 <= '{operation: cmd.operation, reg_select: cmd.reg_select,
				write_data: cmd.write_data, draw_done: cmd.draw_done};
		end
	end

	lltsi_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (vld_s1 && adv),
		.item   (item_s1),
		.res    (res_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) res_s2 <= res_c;
	end

	assign rsp.valid       = vld_s2;
	assign rsp.read_data   = res_s2.read_data;
	assign rsp.lcd_mode    = res_s2.lcd_mode;
	assign rsp.line_number = res_s2.line_number;
	assign rsp.vblank_irq  = res_s2.vblank_irq;
	assign rsp.stat_irq    = res_s2.stat_irq;
	assign rsp.frame_done  = res_s2.frame_done;

	// Empty result register always lets input in
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s2 |-> cmd.ready)
		else $error("input stalled with empty output");
	// Vblank pulse comes with frame done on line 144 in vblank
	a_vblank: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.vblank_irq) |->
		(res_s2.frame_done && (res_s2.lcd_mode == MODE_VBLANK)
		&& (res_s2.line_number == VblankLine)))
		else $error("vblank pulse inconsistent");
	// A word in stage 1 reaches the result register when it is free
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && adv) |=> vld_s2)
		else $error("word lost between stages");

endmodule

// File: design/lltsi_core.sv
`timescale 1ns / 1ps

// Timing state and per-word update; state commits when fire is high
module lltsi_core import lltsi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	output result_t res
);

	logic [8:0] dot_q;
	logic [7:0] line_q;
	logic [1:0] mode_q;
	logic       flag_q;
	logic [4:0] en_q;
	logic       sline_q;
	logic [7:0] ctrl_q;
	logic [7:0] lyc_q;

	logic [8:0] dot_d;
	logic [7:0] line_d;
	logic [1:0] mode_d;
	logic       flag_d;
	logic [4:0] en_d;
	logic       sline_d;
	logic [7:0] ctrl_d;
	logic [7:0] lyc_d;

	logic [8:0] dot_inc;
	logic [7:0] line_inc;
	logic       lvl;

	// Line-compare flag, with the last-line quirks
	function automatic logic cmp_flag(input logic [7:0] line, input logic [8:0] dot,
		input logic [7:0] lyc);
		logic f;
		if (line < LastLine) begin
			f = (lyc == line) && ((dot >= OamStartDot) || (line == 8'd0));
		end else if (lyc == LastLine) begin
			f = (line == LastLine) && (dot >= OamStartDot) && (dot < CmpEndDot);
		end else begin
			f = (lyc == 8'd0) && (dot >= CmpLateDot);
		end
		return f;
	endfunction

	// Combined status interrupt level
	function automatic logic stat_level(input logic on, input logic flag,
		input logic [4:0] en, input logic [1:0] mode);
		return on && ((flag && en[3]) ||
			((mode == MODE_HBLANK) && en[0]) ||
			((mode == MODE_OAM) && en[2]) ||
			((mode == MODE_VBLANK) && (en[1] || en[2])));
	endfunction

	assign dot_inc  = dot_q + 9'd1;
	assign line_inc = line_q + 8'd1;

	always_comb begin
		dot_d   = dot_q;
		line_d  = line_q;
		mode_d  = mode_q;
		flag_d  = flag_q;
		en_d    = en_q;
		sline_d = sline_q;
		ctrl_d  = ctrl_q;
		lyc_d   = lyc_q;
		lvl     = 1'b0;
		res     = '0;

		unique case (item.operation)
			OP_TICK: begin
				if (ctrl_q[7]) begin
					dot_d = dot_inc;
					if (dot_inc == OamStartDot) begin
						if (line_q < VblankLine) begin
							mode_d = MODE_OAM;
						end else if (line_q == VblankLine) begin
							mode_d = MODE_VBLANK;
							res.vblank_irq = 1'b1;
							res.frame_done = 1'b1;
						end
					end else if (dot_inc == DrawStartDot) begin
						if (line_q < VblankLine) mode_d = MODE_DRAW;
					end else if (dot_inc >= DotsPerLine) begin
						dot_d = 9'd0;
						if (line_inc < VblankLine) begin
							line_d = line_inc;
							mode_d = MODE_HBLANK;
						end else if (line_inc >= LinesPerFrame) begin
							line_d = 8'd0;
							mode_d = MODE_HBLANK;
						end else begin
							line_d = line_inc;
						end
					end
					// renderer finished the line
					if ((mode_d == MODE_DRAW) && item.draw_done) mode_d = MODE_HBLANK;
					flag_d = cmp_flag(line_d, dot_d, lyc_q);
					if ((mode_d != mode_q) || (flag_d != flag_q)) begin
						lvl          = stat_level(1'b1, flag_d, en_q, mode_d);
						res.stat_irq = lvl && !sline_q;
						sline_d      = lvl;
					end
				end
			end
			OP_WRITE: begin
				unique case (item.reg_select)
					REG_CTRL: begin
						ctrl_d = item.write_data;
						if (ctrl_q[7] && !item.write_data[7]) begin
							dot_d          = 9'd0;
							line_d         = 8'd0;
							mode_d         = MODE_HBLANK;
							res.frame_done = 1'b1;
						end else if (!ctrl_q[7] && item.write_data[7]) begin
							dot_d        = DotReset;
							line_d       = 8'd0;
							mode_d       = MODE_HBLANK;
							flag_d       = cmp_flag(8'd0, DotReset, lyc_q);
							lvl          = stat_level(1'b1, flag_d, en_q, MODE_HBLANK);
							res.stat_irq = lvl && !sline_q;
							sline_d      = lvl;
						end
					end
					REG_STAT: begin
						en_d         = item.write_data[7:3];
						lvl          = stat_level(ctrl_q[7], flag_q, en_d, mode_q);
						res.stat_irq = lvl && !sline_q;
						sline_d      = lvl;
					end
					REG_LYC: lyc_d = item.write_data;
					default: ;
				endcase
			end
			OP_READ: begin
				unique case (item.reg_select)
					REG_CTRL: res.read_data = ctrl_q;
					REG_STAT: res.read_data = StatTopBit
						| ({1'b0, en_q[3:0], 3'b000} & StatEnMask)
						| {5'd0, flag_q, mode_q};
					REG_LINE: res.read_data = line_q;
					default:  res.read_data = lyc_q;
				endcase
			end
			default: ;
		endcase

		res.lcd_mode    = mode_d;
		res.line_number = line_d;
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q   <= DotReset;
			line_q  <= 8'd0;
			mode_q  <= MODE_HBLANK;
			flag_q  <= 1'b1;
			en_q    <= 5'd0;
			sline_q <= 1'b0;
			ctrl_q  <= CtrlReset;
			lyc_q   <= 8'd0;
		end else if (fire) begin
			dot_q   <= dot_d;
			line_q  <= line_d;
			mode_q  <= mode_d;
			flag_q  <= flag_d;
			en_q    <= en_d;
			sline_q <= sline_d;
			ctrl_q  <= ctrl_d;
			lyc_q   <= lyc_d;
		end
	end

	// Position never leaves the frame
	a_dot_range: assert property (@(posedge clk) disable iff (!arst_n)
		dot_q < DotsPerLine)
		else $error("dot count out of range");
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_q < LinesPerFrame)
		else $error("line out of range");
	// Visible lines never sit in vblank mode
	a_vis_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(line_q < VblankLine) |-> (mode_q != MODE_VBLANK))
		else $error("vblank mode on visible line");

endmodule
